// ===== rtl/core/bmh_pkg.sv =====
package bmh_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = ADDR_W + 2;
  localparam int KEY_W    = 32;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    key_t       push_value;
  } req_t;

  typedef struct packed {
    key_t             min_value;
    logic             is_empty;
    logic [1:0]       status;
    logic [CNT_W-1:0] occupancy;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_CMP,
    S_PLACE,
    S_FINISH
  } state_t;

endpackage

// ===== rtl/core/binary_min_heap.sv =====
// Binary min-heap of signed 32-bit keys held in one 1024-word synchronous RAM
// with one write and two read ports. Each word on in_data is a push, a pop
// or a query (an unused code acts as a query) and yields exactly one word on
// out_data: the minimum afterwards (zero when empty), the empty flag, the
// status and the occupancy. Words are handled one at a time; in_stall is low
// only while the block is idle, and a finished result waits in the output
// register without holding off the next request. A query or a refused
// request goes straight to the result; a push walks up one level at a time
// as the key climbs, and a pop walks down as the moved entry sinks. Each
// level is one RAM read and one compare-and-write. The root key is mirrored
// in a register, so a query never touches the RAM. No clearing pass follows
// reset.
module binary_min_heap (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bmh_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bmh_pkg::rsp_t out_data
);
  import bmh_pkg::*;

  key_t mem [CAPACITY];

  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  key_t              val_r, val_nxt;
  key_t              min_r, min_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_data_r, out_data_nxt;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  key_t              wr_data;
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
  key_t              rd_a_r, rd_b_r;

  logic              accept;
  logic              out_free;
  logic              full, empty;
  logic [ADDR_W-1:0] push_par;
  logic [ADDR_W-1:0] par_addr;
  logic              up_move;
  logic [CHILD_W-1:0] left_w, right_w;
  logic              r_valid;
  logic              take_l, take_r, dn_move;
  key_t              best_v;
  logic [ADDR_W-1:0] child;
  logic [CHILD_W-1:0] child_left, child_right;
  logic              child_has;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  always_comb begin
    full       = (cnt_r == CNT_W'(CAPACITY));
    empty      = (cnt_r == '0);
    push_par   = ADDR_W'((cnt_r - CNT_W'(1)) >> 1);
    par_addr   = (pos_r - ADDR_W'(1)) >> 1;
    up_move    = (rd_a_r > val_r);
    left_w     = {1'b0, pos_r, 1'b1};
    right_w    = {1'b0, pos_r, 1'b0} + CHILD_W'(2);
    r_valid    = (right_w < CHILD_W'(cnt_r));
    take_l     = (val_r > rd_a_r);
    best_v     = take_l ? rd_a_r : val_r;
    take_r     = r_valid && (best_v > rd_b_r);
    dn_move    = take_l || take_r;
    child      = take_r ? right_w[ADDR_W-1:0] : left_w[ADDR_W-1:0];
    child_left  = {1'b0, child, 1'b1};
    child_right = {1'b0, child, 1'b0} + CHILD_W'(2);
    child_has  = (child_left < CHILD_W'(cnt_r));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.req_type)
            REQ_PUSH: state_nxt = (full || empty) ? S_FINISH : S_UP_CMP;
            REQ_POP:  state_nxt = (cnt_r > CNT_W'(1)) ? S_DN_LAST : S_FINISH;
            default:  state_nxt = S_FINISH;
          endcase
        end
      end
      S_UP_CMP: begin
        if (!up_move) begin
          state_nxt = S_FINISH;
        end else if (par_addr == '0) begin
          state_nxt = S_PLACE;
        end
      end
      S_DN_LAST: state_nxt = (cnt_r > CNT_W'(1)) ? S_DN_CMP : S_PLACE;
      S_DN_CMP: begin
        if (!dn_move) begin
          state_nxt = S_FINISH;
        end else if (!child_has) begin
          state_nxt = S_PLACE;
        end
      end
      S_PLACE:  state_nxt = S_FINISH;
      S_FINISH: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    min_nxt       = min_r;
    status_nxt    = status_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = val_r;
    rd_a_addr     = '0;
    rd_b_addr     = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = ST_OK;
          case (in_data.req_type)
            REQ_PUSH: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                cnt_nxt   = cnt_r + CNT_W'(1);
                val_nxt   = in_data.push_value;
                pos_nxt   = cnt_r[ADDR_W-1:0];
                rd_a_addr = push_par;
                if (empty) begin
                  wr_en   = 1'b1;
                  wr_addr = '0;
                  wr_data = in_data.push_value;
                  min_nxt = in_data.push_value;
                end
              end
            end
            REQ_POP: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                cnt_nxt   = cnt_r - CNT_W'(1);
                rd_a_addr = ADDR_W'(cnt_r - CNT_W'(1));
              end
            end
            default: ;
          endcase
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (up_move) begin
          wr_data   = rd_a_r;
          pos_nxt   = par_addr;
          rd_a_addr = (par_addr - ADDR_W'(1)) >> 1;
        end
      end
      S_DN_LAST: begin
        val_nxt   = rd_a_r;
        pos_nxt   = '0;
        rd_a_addr = ADDR_W'(1);
        rd_b_addr = ADDR_W'(2);
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (dn_move) begin
          wr_data   = take_r ? rd_b_r : rd_a_r;
          pos_nxt   = child;
          rd_a_addr = child_left[ADDR_W-1:0];
          rd_b_addr = child_right[ADDR_W-1:0];
        end
        if (pos_r == '0) begin
          min_nxt = wr_data;
        end
      end
      S_PLACE: begin
        wr_en = 1'b1;
        if (pos_r == '0) begin
          min_nxt = val_r;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.min_value = empty ? '0 : min_r;
          out_data_nxt.is_empty  = empty;
          out_data_nxt.status    = status_r;
          out_data_nxt.occupancy = cnt_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    min_r      <= min_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== tb/binary_min_heap_tb.sv =====
`timescale 1ns / 1ps

module binary_min_heap_tb;
  import bmh_pkg::*;

  localparam logic [1:0] REQ_QUERY = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SHOWN_MAX   = 20;

  class min_heap_shadow;
    key_t keys [CAPACITY];
    int   count = 0;
    rsp_t due_results [$];
    int   errors = 0;
    int   checked = 0;
    int   n_push = 0;
    int   n_pop = 0;
    int   n_query = 0;
    int   n_dropped = 0;
    int   n_ignored = 0;
    int   peak = 0;

    task report_mismatch(string msg);
      errors++;
      if (errors <= SHOWN_MAX) begin
        $display("mismatch: %s", msg);
      end
    endtask

    // push sifts up on strict greater-than; pop sifts down, ties keep node then left
    function void note_request(req_t r);
      int   pos;
      int   parent;
      int   left;
      int   right;
      int   best;
      key_t tmp;
      rsp_t want;
      want = '0;
      want.status = ST_OK;
      case (r.req_type)
        REQ_PUSH: begin
          n_push++;
          if (count == CAPACITY) begin
            want.status = ST_FULL;
            n_dropped++;
          end else begin
            pos = count;
            keys[pos] = r.push_value;
            count++;
            while (pos != 0) begin
              parent = (pos - 1) / 2;
              if (!(keys[parent] > keys[pos])) break;
              tmp = keys[parent];
              keys[parent] = keys[pos];
              keys[pos] = tmp;
              pos = parent;
            end
          end
        end
        REQ_POP: begin
          n_pop++;
          if (count == 0) begin
            want.status = ST_EMPTY;
            n_ignored++;
          end else begin
            count--;
            keys[0] = keys[count];
            pos = 0;
            while (1) begin
              left = 2 * pos + 1;
              right = 2 * pos + 2;
              best = pos;
              if (left >= count) break;
              if (keys[best] > keys[left]) best = left;
              if (right < count && keys[best] > keys[right]) best = right;
              if (best == pos) break;
              tmp = keys[best];
              keys[best] = keys[pos];
              keys[pos] = tmp;
              pos = best;
            end
          end
        end
        default: begin
          n_query++;
        end
      endcase
      want.is_empty = (count == 0);
      want.min_value = (count == 0) ? key_t'(0) : keys[0];
      want.occupancy = count[CNT_W-1:0];
      if (count > peak) peak = count;
      due_results.push_back(want);
    endfunction

    task check_response(rsp_t got);
      rsp_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (got.min_value !== want.min_value) begin
        report_mismatch($sformatf("result %0d min_value %0d, want %0d",
                                  checked, got.min_value, want.min_value));
      end
      if (got.is_empty !== want.is_empty) begin
        report_mismatch($sformatf("result %0d is_empty %b, want %b",
                                  checked, got.is_empty, want.is_empty));
      end
      if (got.status !== want.status) begin
        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                  checked, got.status, want.status));
      end
      if (got.occupancy !== want.occupancy) begin
        report_mismatch($sformatf("result %0d occupancy %0d, want %0d",
                                  checked, got.occupancy, want.occupancy));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  bit gaps_on = 1'b0;
  bit quiet = 1'b0;
  int cycles = 0;
  int stall_left = 0;
  int words_sent = 0;
  min_heap_shadow shadow = new();

  binary_min_heap uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (gaps_on && !quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      shadow.check_response(out_data);
    end
  end

  function automatic key_t pick_key();
    key_t k;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 5))
          0: k = 32'sh7fffffff;
          1: k = 32'sh80000000;
          2: k = 32'sh7ffffffe;
          3: k = 32'sh80000001;
          4: k = 32'sd0;
          default: k = -32'sd1;
        endcase
      end
      1, 2: begin
        k = $urandom_range(0, 16);
        k = k - 32'sd8;
      end
      default: k = $urandom();
    endcase
    return k;
  endfunction

  function automatic logic [1:0] pick_kind(int push_w, int pop_w, int query_w);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_w) return REQ_PUSH;
    if (r < push_w + pop_w) return REQ_POP;
    if (r < push_w + pop_w + query_w) return REQ_QUERY;
    return REQ_SPARE;
  endfunction

  task automatic send_word(logic [1:0] kind, key_t key);
    req_t r;
    int   gap;
    words_sent++;
    if (words_sent % 60 == 0) begin
      gaps_on <= ($urandom_range(0, 2) != 0);
    end
    if (!quiet && gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r.req_type = kind;
    r.push_value = key;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.note_request(r);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.due_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    int i;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_word(REQ_QUERY, $urandom());
    send_word(REQ_POP, $urandom());
    send_word(REQ_SPARE, $urandom());
    send_word(REQ_PUSH, 32'sd0);
    send_word(REQ_PUSH, 32'sh7fffffff);
    send_word(REQ_PUSH, 32'sh80000000);
    send_word(REQ_QUERY, $urandom());
    send_word(REQ_PUSH, -32'sd1);
    send_word(REQ_PUSH, 32'sh80000000);
    send_word(REQ_PUSH, 32'sh7fffffff);
    send_word(REQ_PUSH, 32'sd5);
    send_word(REQ_PUSH, 32'sd5);
    send_word(REQ_SPARE, $urandom());
    for (i = 0; i < 8; i++) begin
      send_word(REQ_POP, $urandom());
    end
    send_word(REQ_POP, $urandom());
    send_word(REQ_PUSH, $urandom());
    send_word(REQ_POP, $urandom());

    gaps_on <= 1'b1;
    for (i = 0; i < 200; i++) begin
      if (i == 100) drain_wait();
      send_word(pick_kind(45, 30, 15), pick_key());
    end

    // fill to capacity, then work around the full boundary
    while (shadow.count < CAPACITY) begin
      send_word(pick_kind(95, 0, 5), pick_key());
    end
    send_word(REQ_PUSH, 32'sh80000000);
    send_word(REQ_PUSH, pick_key());
    for (i = 0; i < 16; i++) begin
      send_word(pick_kind(60, 25, 10), pick_key());
    end

    for (i = 0; i < 130; i++) begin
      if (i == 30) quiet <= 1'b1;
      send_word(pick_kind(20, 70, 10), pick_key());
    end

    in_valid <= 1'b0;
    while (shadow.due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d requests: %0d pushes (%0d dropped at full), %0d pops (%0d on empty),",
             words_sent, shadow.n_push, shadow.n_dropped, shadow.n_pop, shadow.n_ignored);
    $display("%0d queries incl. spare code; peak occupancy %0d; %0d results checked.",
             shadow.n_query, shadow.peak, shadow.checked);
    if (shadow.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bmh_pkg.sv
rtl/core/binary_min_heap.sv
tb/binary_min_heap_tb.sv
